### design/dpo_pkg.sv
// shared constants and types of the detrended price oscillator
package dpo_pkg;

    localparam int PRICE_W           = 32;
    localparam int OSC_W             = 33;
    localparam int SUM_W             = 40;
    localparam int PERIOD_W          = 8;
    localparam int WIN_W             = 9;
    localparam int PADDR_W           = 3;
    localparam int PDATA_W           = 32;
    localparam int HISTORY_DEPTH_DEF = 256;
    localparam int DIV_STEPS         = SUM_W;
    localparam int DIV_CNT_W         = $clog2(DIV_STEPS);
    localparam int DVS_W             = 9;
    localparam int REM_W             = 8;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd20;
    localparam logic [WIN_W-1:0]    COUNT_MAX    = 9'd511;

    // register index as decoded from paddr
    localparam logic REG_IDX_PERIOD = 1'b0;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### design/dpo_history_mem.sv
// price history ring: one write port, one registered read port
module dpo_history_mem import dpo_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int AW            = $clog2(HISTORY_DEPTH)
) (
    input  logic               aclk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [PRICE_W-1:0] wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output logic [PRICE_W-1:0] rdata
);

    logic [PRICE_W-1:0] mem [HISTORY_DEPTH];
    logic [PRICE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/dpo_divider.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module dpo_divider import dpo_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [DVS_W-1:0]        divisor,
    output logic signed [SUM_W-1:0] quotient,
    output div_status_t             status
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     mag_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic                 neg_reg;
    logic [DVS_W-1:0]     trial;
    logic                 ge;

    assign trial = {rem_reg, mag_reg[SUM_W-1]};
    assign ge    = (trial >= dvs_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
            neg_reg <= dividend[SUM_W-1];
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? REM_W'(trial - dvs_reg) : trial[REM_W-1:0];
            mag_reg <= {mag_reg[SUM_W-2:0], ge};
        end
    end

    assign quotient    = neg_reg ? $signed(~mag_reg + 1'b1) : $signed(mag_reg);
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### design/detrended_price_oscillator_core.sv
// detrended price oscillator: sequencer, window sum upkeep and config port
// each accepted beat runs through the window sum upkeep, one history read per entry added to
// or dropped from the sum (none while the window fills, one once it is full, up to 255 after
// a period change), the reference read, the ring write and the 40-step divider; a result
// held at the output stalls the sequencer until it is taken; one item in flight, next beat
// taken the cycle after the result enters the output register
// synchronous active-low reset clears control state and sets period to 20;
// the history memory is not cleared
module detrended_price_oscillator_core import dpo_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [PDATA_W-1:0]      pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [PRICE_W-1:0] s_close_price,
    input  logic                    s_series_start,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OSC_W-1:0] m_oscillator
);

    localparam int AW        = $clog2(HISTORY_DEPTH);
    localparam int XW        = ((AW > WIN_W) ? AW : WIN_W) + 1;
    localparam int WIN_CAP   = (HISTORY_DEPTH < 255) ? HISTORY_DEPTH : 255;
    localparam int SHIFT_CAP = (HISTORY_DEPTH - 1 < 255) ? HISTORY_DEPTH - 1 : 255;
    localparam int EXT_W     = SUM_W - PRICE_W;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_ADJ_RD  = 6'b000010,
        S_ADJ_ACC = 6'b000100,
        S_REF_RD  = 6'b001000,
        S_REF_WR  = 6'b010000,
        S_DIV     = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [PERIOD_W-1:0]     period_reg;
    logic [AW-1:0]           wp_reg, wp_next;
    logic [WIN_W-1:0]        count_reg, count_next;
    logic [WIN_W-1:0]        win_reg, win_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [PRICE_W-1:0]      first_reg, first_next;
    logic [PRICE_W-1:0]      price_reg, price_next;
    logic [PRICE_W-1:0]      ref_reg, ref_next;
    logic [AW-1:0]           prev_reg, prev_next;
    logic [WIN_W-1:0]        idx_reg, idx_next;
    logic [WIN_W-1:0]        hi_reg, hi_next;
    logic                    sub_reg, sub_next;
    logic [WIN_W-1:0]        shift_reg, shift_next;
    logic                    use_ref_reg, use_ref_next;
    logic                    m_valid_reg, m_valid_next;
    logic [OSC_W-1:0]        out_reg, out_next;

    logic [WIN_W-1:0]        p_eff, cnt_base, cnt_new, w_old, w_new, k, w_tmp, shift_full;
    logic signed [SUM_W-1:0] sum_base;
    logic [WIN_W-1:0]        rd_off;
    logic [XW-1:0]           oe, be, diff;
    logic                    mem_we, mem_re;
    logic [AW-1:0]           mem_raddr;
    logic [PRICE_W-1:0]      mem_rdata;
    logic                    div_start;
    logic signed [SUM_W-1:0] quotient;
    div_status_t             div_st;
    logic                    accept;
    logic                    cfg_wr;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_IDX_PERIOD);
    assign prdata = (paddr[PADDR_W-1] == REG_IDX_PERIOD) ?
                    PDATA_W'(period_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RESET;
        end else if (cfg_wr) begin
            period_reg <= pwdata[PERIOD_W-1:0];
        end
    end

    // per-item window arithmetic
    assign accept   = s_valid && s_ready;
    assign p_eff    = (period_reg == '0) ? WIN_W'(1) : WIN_W'(period_reg);
    assign cnt_base = s_series_start ? '0 : count_reg;
    assign cnt_new  = (cnt_base == COUNT_MAX) ? cnt_base : cnt_base + 1'b1;
    assign w_old    = s_series_start ? '0 : win_reg;
    assign sum_base = s_series_start ? '0 : sum_reg;
    assign w_tmp    = (p_eff < cnt_new) ? p_eff : cnt_new;
    assign w_new    = (w_tmp > WIN_W'(WIN_CAP)) ? WIN_W'(WIN_CAP) : w_tmp;
    assign k        = w_new - 1'b1;
    assign shift_full = (p_eff >> 1) + 1'b1;

    // ring slot lying rd_off entries before the previous newest sample
    assign rd_off    = (state_reg == S_ADJ_RD) ? idx_reg : shift_reg - 1'b1;
    assign oe        = XW'(prev_reg);
    assign be        = XW'(rd_off);
    assign diff      = (oe >= be) ? oe - be : oe + XW'(HISTORY_DEPTH) - be;
    assign mem_raddr = diff[AW-1:0];
    assign mem_re    = (state_reg == S_ADJ_RD) || (state_reg == S_REF_RD);
    assign mem_we    = (state_reg == S_REF_WR);
    assign div_start = (state_reg == S_REF_WR);

    always_comb begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        count_next   = count_reg;
        win_next     = win_reg;
        sum_next     = sum_reg;
        first_next   = first_reg;
        price_next   = price_reg;
        ref_next     = ref_reg;
        prev_next    = prev_reg;
        idx_next     = idx_reg;
        hi_next      = hi_reg;
        sub_next     = sub_reg;
        shift_next   = shift_reg;
        use_ref_next = use_ref_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_next     = out_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    price_next   = s_close_price;
                    count_next   = cnt_new;
                    win_next     = w_new;
                    sum_next     = sum_base + $signed({{EXT_W{s_close_price[PRICE_W-1]}},
                                                       s_close_price});
                    first_next   = (cnt_base == '0) ? s_close_price : first_reg;
                    prev_next    = (wp_reg == '0) ? AW'(HISTORY_DEPTH - 1) : wp_reg - 1'b1;
                    sub_next     = (k < w_old);
                    idx_next     = (k < w_old) ? k : w_old;
                    hi_next      = (k < w_old) ? w_old : k;
                    shift_next   = (shift_full > WIN_W'(SHIFT_CAP)) ?
                                   WIN_W'(SHIFT_CAP) : shift_full;
                    use_ref_next = ((cnt_new - 1'b1) > ((shift_full > WIN_W'(SHIFT_CAP)) ?
                                   WIN_W'(SHIFT_CAP) : shift_full));
                    state_next   = (k != w_old) ? S_ADJ_RD : S_REF_RD;
                end
            end
            S_ADJ_RD: begin
                state_next = S_ADJ_ACC;
            end
            S_ADJ_ACC: begin
                if (sub_reg) begin
                    sum_next = sum_reg - $signed({{EXT_W{mem_rdata[PRICE_W-1]}}, mem_rdata});
                end else begin
                    sum_next = sum_reg + $signed({{EXT_W{mem_rdata[PRICE_W-1]}}, mem_rdata});
                end
                idx_next   = idx_reg + 1'b1;
                state_next = ((idx_reg + 1'b1) == hi_reg) ? S_REF_RD : S_ADJ_RD;
            end
            S_REF_RD: begin
                state_next = S_REF_WR;
            end
            S_REF_WR: begin
                ref_next   = use_ref_reg ? mem_rdata : first_reg;
                wp_next    = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_st.done && (!m_valid_reg || m_ready)) begin
                    out_next     = {ref_reg[PRICE_W-1], ref_reg} - quotient[OSC_W-1:0];
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            wp_reg      <= '0;
            count_reg   <= '0;
            win_reg     <= '0;
            sum_reg     <= '0;
            first_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            count_reg   <= count_next;
            win_reg     <= win_next;
            sum_reg     <= sum_next;
            first_reg   <= first_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        price_reg   <= price_next;
        ref_reg     <= ref_next;
        prev_reg    <= prev_next;
        idx_reg     <= idx_next;
        hi_reg      <= hi_next;
        sub_reg     <= sub_next;
        shift_reg   <= shift_next;
        use_ref_reg <= use_ref_next;
        out_reg     <= out_next;
    end

    dpo_history_mem #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .AW            (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (wp_reg),
        .wdata (price_reg),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dpo_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (win_reg),
        .quotient (quotient),
        .status   (div_st)
    );

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_oscillator = $signed(out_reg);

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat taken while an item is in flight");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_oscillator))
        else $error("result dropped or changed while waiting");

    a_window_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 |-> (win_reg != '0 && win_reg <= count_reg))
        else $error("window outside sample count");

    a_div_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV && !div_st.busy |-> div_st.done)
        else $error("divider idle without a quotient");

endmodule

### test/detrended_price_oscillator_core_tb.sv
// self-checking testbench for the detrended price oscillator core
module detrended_price_oscillator_core_tb import dpo_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = HISTORY_DEPTH_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 250;
    localparam logic [PADDR_W-1:0] PERIOD_ADDR = {REG_IDX_PERIOD, 2'b00};
    localparam logic signed [PRICE_W-1:0] PRICE_MAX = 32'sh7FFFFFFF;
    localparam logic signed [PRICE_W-1:0] PRICE_MIN = 32'sh80000000;

    class oscillator_tracker;
        logic signed [PRICE_W-1:0] history [DEPTH];
        int unsigned write_slot;
        int unsigned sample_total;
        logic signed [PRICE_W-1:0] series_first;
        int unsigned period;
        logic [OSC_W-1:0] expected_osc [$];
        int errors;
        int checked;

        function new();
            write_slot = 0;
            sample_total = 0;
            series_first = '0;
            period = PERIOD_RESET;
            errors = 0;
            checked = 0;
            foreach (history[i]) history[i] = '0;
        endfunction

        function void set_period(logic [PERIOD_W-1:0] value);
            period = value;
        endfunction

        function int pending();
            return expected_osc.size();
        endfunction

        function void note_sample(logic signed [PRICE_W-1:0] price, logic start);
            int unsigned p;
            int unsigned newest;
            int unsigned span;
            int unsigned lag;
            int unsigned i;
            longint window_total;
            longint mean;
            longint osc;
            logic signed [PRICE_W-1:0] delayed;
            p = (period == 0) ? 1 : period;
            if (start) sample_total = 0;
            if (sample_total == 0) series_first = price;
            newest = write_slot;
            history[newest] = price;
            write_slot = (newest + 1) % DEPTH;
            if (sample_total < COUNT_MAX) sample_total++;
            span = (p < sample_total) ? p : sample_total;
            if (span > DEPTH) span = DEPTH;
            window_total = 0;
            for (i = 0; i < span; i++) begin
                window_total += longint'(history[(newest + DEPTH - i) % DEPTH]);
            end
            lag = p / 2 + 1;
            if (lag > DEPTH - 1) lag = DEPTH - 1;
            if (sample_total - 1 > lag) begin
                delayed = history[(newest + DEPTH - lag) % DEPTH];
            end else begin
                delayed = series_first;
            end
            mean = window_total / longint'(span);
            osc = longint'(delayed) - mean;
            expected_osc.push_back(osc[OSC_W-1:0]);
        endfunction

        task report(string what);
            errors++;
            $display("%s", what);
        endtask

        task check_oscillator(logic [OSC_W-1:0] got);
            logic [OSC_W-1:0] want;
            checked++;
            if (expected_osc.size() == 0) begin
                report($sformatf("oscillator beat %0d arrived with no sample pending: %0d",
                                 checked, $signed(got)));
                return;
            end
            want = expected_osc.pop_front();
            if (got !== want) begin
                report($sformatf("oscillator beat %0d: got %0d, want %0d",
                                 checked, $signed(got), $signed(want)));
            end
        endtask
    endclass

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_W-1:0]        paddr = '0;
    logic [PDATA_W-1:0]        pwdata = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [PRICE_W-1:0] s_close_price = '0;
    logic                      s_series_start = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [OSC_W-1:0]   m_oscillator;

    oscillator_tracker         tracker;
    logic signed [PRICE_W-1:0] walk_price = '0;
    bit                        no_idle = 1'b0;
    int                        results_seen = 0;
    int                        hold_left = 0;
    bit                        hold_done = 1'b0;
    int                        stall_cycles = 0;
    int                        plan [10] = '{1, 254, 0, 2, 3, -1, -1, 254, 1, -1};

    detrended_price_oscillator_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_close_price  (s_close_price),
        .s_series_start (s_series_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_oscillator   (m_oscillator)
    );

    always #2 aclk = ~aclk;

    function automatic logic signed [PRICE_W-1:0] next_price();
        logic signed [PRICE_W-1:0] p;
        case ($urandom_range(9))
            0, 1, 2: p = $urandom;
            3: begin
                case ($urandom_range(3))
                    0: p = PRICE_MAX;
                    1: p = PRICE_MIN;
                    2: p = -1;
                    default: p = '0;
                endcase
            end
            default: p = walk_price + ($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
        walk_price = p;
        return p;
    endfunction

    task automatic offer_sample(logic signed [PRICE_W-1:0] price, logic start);
        while (!no_idle && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_close_price <= price;
        s_series_start <= start;
        do @(posedge aclk); while (!s_ready);
        tracker.note_sample(price, start);
    endtask

    task automatic write_period(logic [PERIOD_W-1:0] value);
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PERIOD_ADDR;
        pwdata <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tracker.set_period(value);
    endtask

    task automatic run_phase(int n, bit carry_on);
        int left;
        int len;
        int k;
        bit carry;
        left = n;
        carry = carry_on;
        while (left > 0) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 60);
            if (len > left) len = left;
            for (k = 0; k < len; k++) begin
                offer_sample(next_price(), (k == 0 && !carry) || $urandom_range(49) == 0);
            end
            carry = 1'b0;
            left -= len;
        end
    endtask

    // result side: random back-pressure plus one long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_oscillator(m_oscillator);
            results_seen++;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen == 400) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || $urandom_range(99) >= 24;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int i;
        tracker = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset period, field extremes and a restart
        offer_sample(PRICE_MAX, 1'b1);
        offer_sample(PRICE_MIN, 1'b0);
        offer_sample(-1, 1'b0);
        offer_sample(0, 1'b0);
        offer_sample(1, 1'b0);
        offer_sample(PRICE_MIN, 1'b1);
        offer_sample(PRICE_MIN, 1'b0);
        write_period(8'd1);
        offer_sample(PRICE_MAX, 1'b0);
        offer_sample(PRICE_MIN, 1'b0);
        offer_sample(32'sh12345678, 1'b0);
        // period 254, changed mid-series
        write_period(8'd254);
        offer_sample(PRICE_MAX, 1'b0);
        offer_sample(32'sh55555555, 1'b0);
        offer_sample(32'shAAAAAAAA, 1'b0);
        // zero period behaves as one
        write_period(8'd0);
        offer_sample(PRICE_MIN, 1'b1);
        offer_sample(PRICE_MAX, 1'b0);
        offer_sample(PRICE_MAX, 1'b0);
        write_period(8'd2);
        offer_sample(-1, 1'b0);
        offer_sample(PRICE_MIN, 1'b0);
        offer_sample(PRICE_MAX, 1'b0);

        // one long series: saturates the count and fills the history ring
        write_period(8'd254);
        for (i = 0; i < 560; i++) begin
            no_idle = i < 150;
            offer_sample(next_price(), i == 0);
        end
        no_idle = 1'b0;

        foreach (plan[j]) begin
            write_period((plan[j] < 0) ? PERIOD_W'($urandom_range(1, 254)) : PERIOD_W'(plan[j]));
            run_phase(50, 1'($urandom_range(1)));
        end

        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (tracker.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### detrended_price_oscillator_core.f
design/dpo_pkg.sv
design/dpo_history_mem.sv
design/dpo_divider.sv
design/detrended_price_oscillator_core.sv
test/detrended_price_oscillator_core_tb.sv
